// ===== rtl/fac_pkg.sv =====
`default_nettype none

package fac_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes of the plane registers
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_LEFT   = 3'd0,
    CFG_PLANE_RIGHT  = 3'd1,
    CFG_PLANE_TOP    = 3'd2,
    CFG_PLANE_BOTTOM = 3'd3,
    CFG_PLANE_NEAR   = 3'd4,
    CFG_PLANE_FAR    = 3'd5
  } cfg_idx_e;

  // Packing: a in bits 15:0, b in 31:16, c in 47:32, d in 63:48
  typedef struct packed {
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] a;
  } plane_t;

  // Load enables of the arithmetic stages inside each plane lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/frustum_aabb_cull.sv =====
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+-------------------------------
// box in   | in_valid_i / in_ready_o          | min_x/y/z_i, max_x/y/z_i
// result   | out_valid_o / out_ready_i        | visible_o
// config   | cfg_valid_i / cfg_ready_o        | cfg_index_i, cfg_data_i
//
// One box per cycle while out_ready_i is high; stages from transfer to result:
// products, per-axis maximum, plane sum and sign, then the visibility OR.
// Each stage holds its item while the next is full, so bubbles collapse and a
// stall on the result side backs up into in_ready_o without loss.
// Reset clears the plane registers (every box visible) and all valid bits.
// Config writes are registered in the plane registers; cfg_ready_o is always high.
`default_nettype none

module frustum_aabb_cull #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0]      min_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      min_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      min_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]      max_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      max_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      max_z_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    visible_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [fac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [fac_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int NumStages = 4;

  fac_pkg::plane_t           plane [fac_pkg::NUM_PLANES];
  fac_pkg::stage_en_t        stage_en;
  logic signed [COORD_WIDTH-1:0] lo [fac_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi [fac_pkg::NUM_AXES];
  logic [fac_pkg::NUM_PLANES-1:0] outside;
  logic [NumStages-1:0]      ld;
  logic [NumStages-1:0]      valid_d, valid_q;
  logic                      visible_q;

  assign cfg_ready_o = 1'b1;

  fac_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .plane_o     (plane)
  );

  // A stage loads when it is empty or its item moves on this cycle
  always_comb begin
    ld[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      ld[s] = !valid_q[s] || ld[s+1];
    end
    valid_d[0] = ld[0] ? in_valid_i : valid_q[0];
    for (int s = 1; s < NumStages; s++) begin
      valid_d[s] = ld[s] ? valid_q[s-1] : valid_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ld[0];
  assign stage_en.s1 = ld[0];
  assign stage_en.s2 = ld[1];
  assign stage_en.s3 = ld[2];

  assign lo[0] = min_x_i;
  assign lo[1] = min_y_i;
  assign lo[2] = min_z_i;
  assign hi[0] = max_x_i;
  assign hi[1] = max_y_i;
  assign hi[2] = max_z_i;

  for (genvar p = 0; p < fac_pkg::NUM_PLANES; p++) begin : g_lane
    fac_plane_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (stage_en),
      .plane_i   (plane[p]),
      .lo_i      (lo),
      .hi_i      (hi),
      .outside_o (outside[p])
    );
  end

  // reject when any plane has all corners outside
  always_ff @(posedge clk_i) begin
    if (ld[NumStages-1]) begin
      visible_q <= ~|outside;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign visible_o   = visible_q;

  a_ready_when_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input stalled with an empty result stage");

  a_transfer_enters: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0]
  ) else $error("accepted box did not enter the first stage");

  a_full_blocks: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !out_ready_i |-> !in_ready_o
  ) else $error("full pipeline took a new box under a stall");

  a_drain_moves: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_q[NumStages-2] && !out_valid_o |=> out_valid_o
  ) else $error("item in the sum stage did not reach the output");

endmodule

`default_nettype wire

// ===== rtl/fac_plane_regs.sv =====
`default_nettype none

module fac_plane_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [fac_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [fac_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output fac_pkg::plane_t                           plane_o [fac_pkg::NUM_PLANES]
);

  fac_pkg::plane_t plane_q [fac_pkg::NUM_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < fac_pkg::NUM_PLANES; p++) begin
        plane_q[p] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i <= fac_pkg::CFG_PLANE_FAR)) begin
      // indexes past the far plane are dropped
      plane_q[cfg_index_i] <= fac_pkg::plane_t'(cfg_data_i);
    end
  end

  assign plane_o = plane_q;

endmodule

`default_nettype wire

// ===== rtl/fac_plane_lane.sv =====
`default_nettype none

module fac_plane_lane #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire fac_pkg::stage_en_t            en_i,
  input  wire fac_pkg::plane_t               plane_i,
  input  wire logic signed [COORD_WIDTH-1:0] lo_i [fac_pkg::NUM_AXES],
  input  wire logic signed [COORD_WIDTH-1:0] hi_i [fac_pkg::NUM_AXES],
  output logic                               outside_o
);

  localparam int ProdW = fac_pkg::COEF_W + COORD_WIDTH;
  localparam int OffW  = fac_pkg::COEF_W + fac_pkg::FRAC_BITS;
  localparam int SumW  = ((ProdW > OffW) ? ProdW : OffW) + 2;

  logic signed [fac_pkg::COEF_W-1:0] n [fac_pkg::NUM_AXES];
  logic signed [ProdW-1:0] prod_lo_q [fac_pkg::NUM_AXES];
  logic signed [ProdW-1:0] prod_hi_q [fac_pkg::NUM_AXES];
  logic signed [ProdW-1:0] best_q    [fac_pkg::NUM_AXES];
  logic signed [SumW-1:0]  offset;
  logic signed [SumW-1:0]  sum;
  logic                    outside_q;

  assign n[0] = plane_i.a;
  assign n[1] = plane_i.b;
  assign n[2] = plane_i.c;

  // stage 1: both corner products on every axis
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int k = 0; k < fac_pkg::NUM_AXES; k++) begin
        prod_lo_q[k] <= ProdW'(n[k]) * ProdW'(lo_i[k]);
        prod_hi_q[k] <= ProdW'(n[k]) * ProdW'(hi_i[k]);
      end
    end
  end

  // stage 2: keep the larger product per axis
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int k = 0; k < fac_pkg::NUM_AXES; k++) begin
        best_q[k] <= (prod_lo_q[k] > prod_hi_q[k]) ? prod_lo_q[k] : prod_hi_q[k];
      end
    end
  end

  // stage 3: the farthest corner is outside when the best sum goes negative
  assign offset = SumW'(plane_i.d) <<< fac_pkg::FRAC_BITS;
  assign sum    = SumW'(best_q[0]) + SumW'(best_q[1]) + SumW'(best_q[2]) + offset;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      outside_q <= sum[SumW-1];
    end
  end

  assign outside_o = outside_q;

endmodule

`default_nettype wire
